/* rtl/rhre_pkg.sv */
// Shared types, codes and constants of the RGB histogram rebin engine.
// Depends on nothing; every other file of the block imports it.
package rhre_pkg;

   localparam int LEVELS_DEF     = 256;
   localparam int MAX_BINS_DEF   = 64;
   localparam int COUNT_BITS_DEF = 24;

   localparam int PIX_W  = 8;
   localparam int SUM_W  = 24;
   localparam int IDX_W  = 6;
   localparam int MODE_W = 2;

   localparam int BINS_MODE0 = 16;
   localparam int BINS_MODE1 = 32;
   localparam int BINS_MODE2 = 64;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_PIXEL = 2'd1,
      OP_END   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_BIN    = 2'd0,
      RSP_COMMIT = 2'd1,
      RSP_EMPTY  = 2'd2
   } rsp_status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_16     = 2'd0,
      MODE_32     = 2'd1,
      MODE_64     = 2'd2,
      MODE_64_ALT = 2'd3
   } bin_mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_WR,
      ST_COPY,
      ST_END_RSP,
      ST_RD_ISSUE,
      ST_RD_DRAIN,
      ST_RD_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic           clear_wr;
      logic           pix_rd;
      logic           pix_wr;
      logic           copy_rd;
      logic           shown_set;
      logic           cnt_clr;
      logic           show_rd;
      logic           peak_clr;
      logic           emit_bin;
      logic           bin_last;
      logic           emit_end;
      rsp_status_type end_status;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic frame_nonzero;
   } dp_sts_type;

   function automatic int clamp_bins(int choice, int max_bins, int levels);
      int b;
      b = choice;
      if (b > max_bins) b = max_bins;
      if (b > levels) b = levels;
      return b;
   endfunction

endpackage

/* rtl/rhre_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on rhre_pkg for payload types and widths.
interface rhre_req_if;
   import rhre_pkg::*;
   logic             valid;
   logic             ready;
   op_type           op;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   modport source (output valid, op, red, green, blue, input ready);
   modport sink   (input valid, op, red, green, blue, output ready);
endinterface

interface rhre_rsp_if;
   import rhre_pkg::*;
   logic             valid;
   logic             ready;
   rsp_status_type   status;
   logic [IDX_W-1:0] bin_index;
   logic [SUM_W-1:0] sum_red;
   logic [SUM_W-1:0] sum_green;
   logic [SUM_W-1:0] sum_blue;
   logic [SUM_W-1:0] peak;
   logic             last;
   modport source (output valid, status, bin_index, sum_red, sum_green, sum_blue, peak, last,
                   input ready);
   modport sink   (input valid, status, bin_index, sum_red, sum_green, sum_blue, peak, last,
                   output ready);
endinterface

/* rtl/rgb_histogram_rebin_engine.sv */
// RGB histogram rebin engine: counts per-channel level histograms and reads them out in bins.
// A pixel is a read-modify-write through the registered read port of the per-channel
// counter memory. Start runs a clearing sweep of the working counts, a committing end a
// copy sweep into the shown counts plus the status transfer, and a readout one shown
// memory read per level of each bin. After reset the block runs the same clearing sweep
// before it accepts its first request; bin mode writes are taken at any time. Depends on
// rhre_pkg, rhre_ifs, rhre_ctrl and rhre_datapath.
module rgb_histogram_rebin_engine #(
   parameter int LEVELS     = rhre_pkg::LEVELS_DEF,
   parameter int MAX_BINS   = rhre_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = rhre_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   rhre_req_if.sink                     req_chan,
   rhre_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [rhre_pkg::MODE_W-1:0]  csr_wr_data
);
   import rhre_pkg::*;

   // The controller owns the request side and the bin mode register; the datapath owns the
   // memories and the output register, so a finished result waits there while the next
   // request is already accepted.
   dp_cmd_type                cmd;
   dp_sts_type                sts;
   logic [$clog2(LEVELS)-1:0] sweep_addr;
   logic [IDX_W-1:0]          bin_idx;

   rhre_ctrl #(
      .LEVELS   (LEVELS),
      .MAX_BINS (MAX_BINS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .sweep_addr  (sweep_addr),
      .bin_idx     (bin_idx)
   );

   rhre_datapath #(
      .LEVELS     (LEVELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .sweep_addr (sweep_addr),
      .bin_idx    (bin_idx),
      .pix_red    (req_chan.red),
      .pix_green  (req_chan.green),
      .pix_blue   (req_chan.blue),
      .rsp        (rsp_chan)
   );

`ifndef SYNTHESIS
   // A result is only loaded when the output register is free or being emptied.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_bin || cmd.emit_end) |-> sts.out_free)
      else $error("result loaded into a busy output register");

   // An accepted pixel holds off the next request for its write cycle.
   a_pix_stall: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.op == OP_PIXEL) |=> !req_chan.ready)
      else $error("request accepted during a pixel counter update");

   // End-frame status transfers always close their sequence.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == RSP_COMMIT || rsp_chan.status == RSP_EMPTY))
      |-> rsp_chan.last)
      else $error("end-frame status without last");
`endif

endmodule

/* rtl/rhre_datapath.sv */
// Datapath: working and shown count memories, bin accumulators, peak and output register.
// Depends on rhre_pkg and rhre_ifs; driven by commands from rhre_ctrl.
module rhre_datapath #(
   parameter int LEVELS     = rhre_pkg::LEVELS_DEF,
   parameter int COUNT_BITS = rhre_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rhre_pkg::dp_cmd_type                cmd,
   output rhre_pkg::dp_sts_type                sts,
   input  logic [$clog2(LEVELS)-1:0]           sweep_addr,
   input  logic [rhre_pkg::IDX_W-1:0]          bin_idx,
   input  logic [rhre_pkg::PIX_W-1:0]          pix_red,
   input  logic [rhre_pkg::PIX_W-1:0]          pix_green,
   input  logic [rhre_pkg::PIX_W-1:0]          pix_blue,
   rhre_rsp_if.source                          rsp
);
   import rhre_pkg::*;

   localparam int LVL_W = $clog2(LEVELS);
   localparam int CB    = COUNT_BITS;
   localparam logic [CB-1:0] CMAX = '1;

   function automatic logic [LVL_W-1:0] level_of(logic [PIX_W-1:0] v);
      if (int'(v) >= LEVELS) return LVL_W'(LEVELS - 1);
      return LVL_W'(v);
   endfunction

   function automatic logic [CB-1:0] sat_inc(logic [CB-1:0] v);
      return (v == CMAX) ? v : CB'(v + 1'b1);
   endfunction

   function automatic logic [CB-1:0] sat_add(logic [CB-1:0] a, logic [CB-1:0] b);
      logic [CB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CB] ? CMAX : s[CB-1:0];
   endfunction

   logic [LVL_W-1:0] pix_lvl [3];
   logic [CB-1:0]    acc     [3];

   logic             copy_wr_ff, copy_wr_in;
   logic [LVL_W-1:0] copy_addr_ff;
   logic             acc_en_ff;
   logic             shown_ld_ff, shown_ld_in;
   logic [CB-1:0]    cnt_ff, cnt_in;
   logic [CB-1:0]    peak_ff, peak_in, peak_next;

   assign pix_lvl[0] = level_of(pix_red);
   assign pix_lvl[1] = level_of(pix_green);
   assign pix_lvl[2] = level_of(pix_blue);
   assign copy_wr_in = cmd.copy_rd;

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [CB-1:0]    work_mem  [LEVELS];
      logic [CB-1:0]    shown_mem [LEVELS];
      logic [CB-1:0]    wk_q_ff;
      logic [CB-1:0]    sh_q_ff;
      logic [LVL_W-1:0] lvl_ff;
      logic [CB-1:0]    acc_ff, acc_in;
      logic [LVL_W-1:0] wk_rd_addr, wk_wr_addr;
      logic [CB-1:0]    wk_wr_data, sh_val;
      logic             wk_wr_en;

      always_comb begin
         wk_rd_addr = cmd.pix_rd ? pix_lvl[ch] : sweep_addr;
         wk_wr_en   = cmd.clear_wr | cmd.pix_wr;
         wk_wr_addr = cmd.pix_wr ? lvl_ff : sweep_addr;
         wk_wr_data = cmd.pix_wr ? sat_inc(wk_q_ff) : '0;
         // Shown counts read as zero until the first frame is committed.
         sh_val     = shown_ld_ff ? sh_q_ff : '0;
         if (cmd.peak_clr || cmd.emit_bin) begin
            acc_in = '0;
         end else if (acc_en_ff) begin
            acc_in = sat_add(acc_ff, sh_val);
         end else begin
            acc_in = acc_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (wk_wr_en) begin
            work_mem[wk_wr_addr] <= wk_wr_data;
         end
         wk_q_ff <= work_mem[wk_rd_addr];
         if (copy_wr_ff) begin
            shown_mem[copy_addr_ff] <= wk_q_ff;
         end
         sh_q_ff <= shown_mem[sweep_addr];
      end

      always_ff @(posedge clock) begin
         if (cmd.pix_rd) begin
            lvl_ff <= pix_lvl[ch];
         end
         acc_ff <= acc_in;
      end

      assign acc[ch] = acc_ff;
   end

   always_comb begin
      peak_next = peak_ff;
      if (acc[0] > peak_next) peak_next = acc[0];
      if (acc[1] > peak_next) peak_next = acc[1];
      if (acc[2] > peak_next) peak_next = acc[2];
      peak_in = cmd.peak_clr ? '0 : (cmd.emit_bin ? peak_next : peak_ff);
      cnt_in  = cmd.cnt_clr ? '0 : (cmd.pix_wr ? sat_inc(cnt_ff) : cnt_ff);
      shown_ld_in = shown_ld_ff | cmd.shown_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_wr_ff  <= 1'b0;
         acc_en_ff   <= 1'b0;
         shown_ld_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         copy_wr_ff  <= copy_wr_in;
         acc_en_ff   <= cmd.show_rd;
         shown_ld_ff <= shown_ld_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= sweep_addr;
      peak_ff      <= peak_in;
   end

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_status_type   status_ff;
   logic [IDX_W-1:0] index_ff;
   logic [SUM_W-1:0] sr_ff, sg_ff, sb_ff, pk_ff;
   logic             last_ff;

   assign rsp_valid_in = cmd.emit_bin | cmd.emit_end | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_bin) begin
         status_ff <= RSP_BIN;
         index_ff  <= bin_idx;
         sr_ff     <= SUM_W'(acc[0]);
         sg_ff     <= SUM_W'(acc[1]);
         sb_ff     <= SUM_W'(acc[2]);
         pk_ff     <= SUM_W'(peak_next);
         last_ff   <= cmd.bin_last;
      end else if (cmd.emit_end) begin
         status_ff <= cmd.end_status;
         index_ff  <= '0;
         sr_ff     <= '0;
         sg_ff     <= '0;
         sb_ff     <= '0;
         pk_ff     <= '0;
         last_ff   <= 1'b1;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.bin_index = index_ff;
   assign rsp.sum_red   = sr_ff;
   assign rsp.sum_green = sg_ff;
   assign rsp.sum_blue  = sb_ff;
   assign rsp.peak      = pk_ff;
   assign rsp.last      = last_ff;

   assign sts.out_free      = ~rsp_valid_ff | rsp.ready;
   assign sts.frame_nonzero = (cnt_ff != '0);

endmodule

/* rtl/rhre_ctrl.sv */
// Controller: request handshake, bin mode register, sweep and bin counters, state machine.
// Depends on rhre_pkg and rhre_ifs; commands rhre_datapath.
module rhre_ctrl #(
   parameter int LEVELS   = rhre_pkg::LEVELS_DEF,
   parameter int MAX_BINS = rhre_pkg::MAX_BINS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   rhre_req_if.sink                     req,
   input  logic                         csr_wr_en,
   input  logic [rhre_pkg::MODE_W-1:0]  csr_wr_data,
   output rhre_pkg::dp_cmd_type         cmd,
   input  rhre_pkg::dp_sts_type         sts,
   output logic [$clog2(LEVELS)-1:0]    sweep_addr,
   output logic [rhre_pkg::IDX_W-1:0]   bin_idx
);
   import rhre_pkg::*;

   localparam int LVL_W = $clog2(LEVELS);
   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int B0 = clamp_bins(BINS_MODE0, MAX_BINS, LEVELS);
   localparam int B1 = clamp_bins(BINS_MODE1, MAX_BINS, LEVELS);
   localparam int B2 = clamp_bins(BINS_MODE2, MAX_BINS, LEVELS);
   localparam int P0 = LEVELS / B0;
   localparam int P1 = LEVELS / B1;
   localparam int P2 = LEVELS / B2;
   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

   ctrl_state_type   state_ff, state_in;
   logic [LVL_W-1:0] addr_ff, addr_in;
   logic [LVL_W-1:0] inbin_ff, inbin_in;
   logic [BIN_W-1:0] bin_ff, bin_in;
   bin_mode_type     mode_ff;
   logic [LVL_W-1:0] per_m1;
   logic [BIN_W-1:0] nbins_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_64;
      end else if (csr_wr_en) begin
         mode_ff <= bin_mode_type'(csr_wr_data);
      end
   end

   always_comb begin
      unique case (mode_ff)
         MODE_16: begin
            per_m1   = LVL_W'(P0 - 1);
            nbins_m1 = BIN_W'(B0 - 1);
         end
         MODE_32: begin
            per_m1   = LVL_W'(P1 - 1);
            nbins_m1 = BIN_W'(B1 - 1);
         end
         MODE_64, MODE_64_ALT: begin
            per_m1   = LVL_W'(P2 - 1);
            nbins_m1 = BIN_W'(B2 - 1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         inbin_ff <= '0;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         inbin_ff <= inbin_in;
         bin_ff   <= bin_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      inbin_in  = inbin_ff;
      bin_in    = bin_ff;
      cmd       = '0;
      cmd.end_status = RSP_BIN;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            addr_in      = LVL_W'(addr_ff + 1'b1);
            if (addr_ff == LAST_LVL) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               unique case (req.op)
                  OP_START: begin
                     cmd.cnt_clr = 1'b1;
                     addr_in     = '0;
                     state_in    = ST_CLEAR;
                  end
                  OP_PIXEL: begin
                     cmd.pix_rd = 1'b1;
                     state_in   = ST_PIX_WR;
                  end
                  OP_END: begin
                     addr_in  = '0;
                     state_in = sts.frame_nonzero ? ST_COPY : ST_END_RSP;
                  end
                  OP_READ: begin
                     cmd.peak_clr = 1'b1;
                     addr_in      = '0;
                     inbin_in     = '0;
                     bin_in       = '0;
                     state_in     = ST_RD_ISSUE;
                  end
               endcase
            end
         end
         ST_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_rd   = 1'b1;
            cmd.shown_set = 1'b1;
            addr_in       = LVL_W'(addr_ff + 1'b1);
            if (addr_ff == LAST_LVL) begin
               addr_in  = '0;
               state_in = ST_END_RSP;
            end
         end
         ST_END_RSP: begin
            if (sts.out_free) begin
               cmd.emit_end   = 1'b1;
               cmd.end_status = sts.frame_nonzero ? RSP_COMMIT : RSP_EMPTY;
               state_in       = ST_IDLE;
            end
         end
         ST_RD_ISSUE: begin
            cmd.show_rd = 1'b1;
            addr_in     = LVL_W'(addr_ff + 1'b1);
            if (inbin_ff == per_m1) begin
               inbin_in = '0;
               state_in = ST_RD_DRAIN;
            end else begin
               inbin_in = LVL_W'(inbin_ff + 1'b1);
            end
         end
         ST_RD_DRAIN: begin
            state_in = ST_RD_EMIT;
         end
         ST_RD_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_bin = 1'b1;
               cmd.bin_last = (bin_ff == nbins_m1);
               if (bin_ff == nbins_m1) begin
                  state_in = ST_IDLE;
               end else begin
                  bin_in   = BIN_W'(bin_ff + 1'b1);
                  state_in = ST_RD_ISSUE;
               end
            end
         end
      endcase
   end

   assign sweep_addr = addr_ff;
   assign bin_idx    = IDX_W'(bin_ff);

endmodule

/* tb/sv/tb_rhre_checker.sv */
// Scoreboard for the RGB histogram rebin engine: watches the request and response
// channels, keeps its own histogram state and compares every response transfer.
// Depends on rhre_pkg and the rhre_req_if / rhre_rsp_if interfaces.
`timescale 1ns / 1ps
module tb_rhre_checker
   import rhre_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   rhre_req_if.sink       req_mon,
   rhre_rsp_if.sink       rsp_mon,
   input  logic           csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   output int             fail_count,
   output int             pending_count
);

   typedef struct packed {
      rsp_status_type   status;
      logic [IDX_W-1:0] bin_index;
      logic [SUM_W-1:0] sum_red;
      logic [SUM_W-1:0] sum_green;
      logic [SUM_W-1:0] sum_blue;
      logic [SUM_W-1:0] peak;
      logic             last;
   } bin_rsp_type;

   localparam logic [SUM_W-1:0] CNT_MAX = '1;
   localparam logic [SUM_W-1:0] CNT_ONE = SUM_W'(1);

   logic [SUM_W-1:0] work_cnt [3][256];
   logic [SUM_W-1:0] shown_cnt [3][256];
   logic [SUM_W-1:0] frame_pixels;
   bin_mode_type     mode_shadow;
   bin_rsp_type      expected_rsps [$];

   function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? CNT_MAX : s[SUM_W-1:0];
   endfunction

   task automatic predict_request(op_type op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      bin_rsp_type rsp;
      int          nbins, width;
      logic [SUM_W-1:0] sums [3];
      logic [SUM_W-1:0] pk;
      case (op)
         OP_START: begin
            foreach (work_cnt[c, l]) work_cnt[c][l] = '0;
            frame_pixels = '0;
         end
         OP_PIXEL: begin
            work_cnt[0][r] = add_sat(work_cnt[0][r], CNT_ONE);
            work_cnt[1][g] = add_sat(work_cnt[1][g], CNT_ONE);
            work_cnt[2][b] = add_sat(work_cnt[2][b], CNT_ONE);
            frame_pixels   = add_sat(frame_pixels, CNT_ONE);
         end
         OP_END: begin
            rsp = '0;
            rsp.last = 1'b1;
            if (frame_pixels != 0) begin
               shown_cnt = work_cnt;
               rsp.status = RSP_COMMIT;
            end else begin
               rsp.status = RSP_EMPTY;
            end
            expected_rsps.push_back(rsp);
         end
         default: begin
            case (mode_shadow)
               MODE_16: nbins = BINS_MODE0;
               MODE_32: nbins = BINS_MODE1;
               default: nbins = BINS_MODE2;
            endcase
            width = 256 / nbins;
            pk = '0;
            for (int bi = 0; bi < nbins; bi++) begin
               for (int c = 0; c < 3; c++) begin
                  sums[c] = '0;
                  for (int k = 0; k < width; k++)
                     sums[c] = add_sat(sums[c], shown_cnt[c][bi*width+k]);
                  if (sums[c] > pk) pk = sums[c];
               end
               rsp.status    = RSP_BIN;
               rsp.bin_index = IDX_W'(bi);
               rsp.sum_red   = sums[0];
               rsp.sum_green = sums[1];
               rsp.sum_blue  = sums[2];
               rsp.peak      = pk;
               rsp.last      = (bi == nbins - 1);
               expected_rsps.push_back(rsp);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      bin_rsp_type got, want;
      if (reset) begin
         foreach (work_cnt[c, l]) begin
            work_cnt[c][l]  = '0;
            shown_cnt[c][l] = '0;
         end
         frame_pixels = '0;
         mode_shadow  = MODE_64;
         expected_rsps.delete();
         fail_count   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.bin_index, rsp_mon.sum_red, rsp_mon.sum_green,
                    rsp_mon.sum_blue, rsp_mon.peak, rsp_mon.last};
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response transfer: %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         // Requests are predicted after the response check of the same edge, since a
         // response accepted here cannot be caused by a request accepted here.
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.op, req_mon.red, req_mon.green, req_mon.blue);
         if (csr_wr_en) mode_shadow = bin_mode_type'(csr_wr_data);
      end
      pending_count = expected_rsps.size();
   end

endmodule

/* tb/sv/tb_rgb_histogram_rebin_engine.sv */
// Top of the RGB histogram rebin engine testbench: clock, reset, stimulus and verdict.
// Depends on rhre_pkg, the channel interfaces, the engine RTL and tb_rhre_checker.
`timescale 1ns / 1ps
module tb_rgb_histogram_rebin_engine;
   import rhre_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;
   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;

   // Idle percentages for the sender and the receiver; changed between phases.
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_off_cycles = 0;

   rhre_req_if req_chan ();
   rhre_rsp_if rsp_chan ();

   rgb_histogram_rebin_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tb_rhre_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op    = OP_START;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      rsp_chan.ready = 1'b0;
   end

   // The receiver stalls at random; a requested hold-off keeps ready low for a long
   // stretch so that the engine backs up and stops taking requests.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready  <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The run is ended here if it hangs. A readout of 64 bins and a committing end are long
   // requests; a few thousand requests of that cost fit well.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offers one request and holds it until its transfer; idle cycles come first.
   // Valid stays high after the transfer so that a following request can go back
   // to back; the sender drops it only when it idles.
   task automatic send_request(op_type op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.red   <= r;
      req_chan.green <= g;
      req_chan.blue  <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Withdraws the request side and lets the scoreboard see the last transfer.
   task automatic idle_request();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      send_request(OP_PIXEL, r, g, b);
   endtask

   // Waits until every expected response has come and the engine has had time to
   // finish a start or pixel that leaves no response behind, then writes bin mode.
   task automatic drain_then_set_mode(bin_mode_type mode);
      idle_request();
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // A random frame: start, a few pixels, end and a readout. Half the frames are well
   // formed; the others lack the start, the pixels or the end, or carry a stray request.
   task automatic random_frame();
      int npix;
      int shape;
      shape = $urandom_range(9);
      npix  = (shape == 0) ? 0 : $urandom_range(12, 1);
      if (shape != 1) send_request(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
      for (int i = 0; i < npix; i++) begin
         if ($urandom_range(3) == 0)
            send_pixel(8'($urandom_range(3) * 85), 8'($urandom), 8'($urandom_range(7)));
         else
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
      if (shape == 2)
         send_request(op_type'($urandom_range(3)), 8'($urandom), 8'($urandom),
                      8'($urandom));
      if (shape != 3) send_request(OP_END, 8'($urandom), 8'($urandom), 8'($urandom));
      if (shape == 4) send_request(OP_END, '0, '0, '0);
      send_request(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reads and an end before any pixel, value extremes, repeated
      // end, pixels without start, and the unused bin mode.
      send_request(OP_READ, '0, '0, '0);
      send_request(OP_END, '1, '1, '1);
      send_pixel('0, '1, 8'h55);
      send_pixel('1, '0, 8'hAA);
      send_pixel(8'h0F, 8'hF0, '1);
      send_request(OP_END, '0, '0, '0);
      send_request(OP_END, '0, '0, '0);
      send_request(OP_READ, '0, '0, '0);
      send_request(OP_START, '1, '1, '1);
      send_request(OP_END, '0, '0, '0);
      drain_then_set_mode(MODE_16);
      send_pixel(8'h80, 8'h7F, 8'h01);
      send_request(OP_END, '0, '0, '0);
      send_request(OP_READ, '0, '0, '0);
      drain_then_set_mode(MODE_64_ALT);
      send_request(OP_READ, '0, '0, '0);
      drain_then_set_mode(MODE_32);
      send_request(OP_READ, '0, '0, '0);

      // Random phases, each under its own bin mode and idling mix.
      for (int phase = 0; phase < 8; phase++) begin
         drain_then_set_mode(bin_mode_type'($urandom_range(3)));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         if (phase == 4) hold_off_cycles = 2000;
         for (int f = 0; f < 4; f++) random_frame();
         // In phase 2 the sender pauses until every expected response has come.
         if (phase == 2) begin
            idle_request();
            while (pending_count != 0) @(posedge clock);
         end
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      idle_request();
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
